[rtl/mmb_pkg.sv]
// Shared codes and constants for the matrix-to-bitmap packer.
`default_nettype none
package mmb_pkg;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_MODULE = 2'd1;
   localparam logic [1:0] CMD_DRAIN = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_WAIT = 2'd1;
   localparam logic [1:0] STATUS_REFUSED = 2'd2;
   localparam logic [1:0] STATUS_IDLE = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TOP = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_BOTTOM = 2'd3;

   // what follows once the pending pixels are packed
   localparam logic [1:0] FIN_NONE = 2'd0;
   localparam logic [1:0] FIN_BORDER = 2'd1;
   localparam logic [1:0] FIN_FLUSH = 2'd2;

   localparam logic [0:0] REG_SIDE = 1'b0;
   localparam logic [0:0] REG_DOT = 1'b1;

   localparam logic [7:0] BYTE_WHITE = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   localparam logic [7:0] SIDE_RESET = 8'd21;
   localparam logic [3:0] DOT_RESET = 4'd1;

endpackage
`default_nettype wire

[rtl/mmb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[rtl/module_matrix_to_mono_bitmap.sv]
// Top level: code-module matrix to 1 bit per pixel bitmap packer with row store.
// Each transfer gives one result; start and module items pass through one packed pixel
// chunk per step (plus flush and pad steps at a row end), data-row drains go through
// the row store read, plus the row set-up chunks after the last repeat of a row.
// Throughput: one item at a time, set by the pixel packing sequencer and the RAM read.
// Reset: synchronous; no image active, registers back to side 21 and dot size 1.
`default_nettype none
module module_matrix_to_mono_bitmap #(
   parameter int MAX_ROW_BYTES = 256,
   parameter int MAX_SIDE = 177,
   parameter int MAX_DOT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic        req_dark,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_byte_out,
   output logic             rsp_byte_valid,
   output logic             rsp_last_byte,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import mmb_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
   localparam int MAX_LINE = ((MAX_SIDE + 4) * MAX_DOT + 7) / 8 + 1;
   localparam int LINE_W = $clog2(MAX_LINE + 1);
   localparam int CNT_W = (LINE_W > ADDR_W) ? LINE_W : ADDR_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PIX = 3'd1;
   localparam logic [2:0] S_FLUSH = 3'd2;
   localparam logic [2:0] S_PAD = 3'd3;
   localparam logic [2:0] S_READ = 3'd4;

   logic [7:0] side_ff, side_in;
   logic [3:0] dot_ff, dot_in;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       acc_ff, acc_in;
   logic [2:0]       bc_ff, bc_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] emit_ff, emit_in;
   logic [3:0]       rep_ff, rep_in;
   logic [7:0]       col_ff, col_in;
   logic [7:0]       row_ff, row_in;
   logic [7:0]       aside_ff, aside_in;
   logic [3:0]       adot_ff, adot_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] line_ff, line_in;
   logic [4:0]       pend_ff, pend_in;
   logic             white_ff, white_in;
   logic [1:0]       fin_ff, fin_in;
   logic             rdzero_ff, rdzero_in;
   logic             rdbegin_ff, rdbegin_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_bv_ff, rsp_bv_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic             wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]       wr_data, rd_data;

   logic        accept, csr_write;
   logic [7:0]  start_side;
   logic [3:0]  start_dot;
   logic [12:0] start_bits;
   logic [12:0] start_fill;
   logic [3:0]  room, take, sum;
   logic [7:0]  mask;
   logic [CNT_W:0] emit_next;
   logic [4:0]  rep_next;
   logic [8:0]  row_next;
   logic [8:0]  col_next;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_SIDE) ? {24'd0, side_ff} : {28'd0, dot_ff};

   always_comb begin
      side_in = side_ff;
      dot_in = dot_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_SIDE) begin
            side_in = csr_pwdata[7:0];
         end else begin
            dot_in = csr_pwdata[3:0];
         end
      end
   end

   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bv_ff;
   assign rsp_last_byte = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   // clamped geometry sampled at start
   always_comb begin
      start_side = (side_ff == 8'd0) ? 8'd1 : side_ff;
      if (start_side > 8'(MAX_SIDE)) begin
         start_side = 8'(MAX_SIDE);
      end
      start_dot = (dot_ff == 4'd0) ? 4'd1 : dot_ff;
      if (start_dot > 4'(MAX_DOT)) begin
         start_dot = 4'(MAX_DOT);
      end
      start_bits = (13'({5'd0, start_side}) + 13'd4) * 13'({9'd0, start_dot});
      start_fill = (start_bits + 13'd7) >> 3;
   end

   // pixel chunk: as many pending bits as fit in the current byte
   always_comb begin
      room = 4'd8 - {1'b0, bc_ff};
      take = (pend_ff < {1'b0, room}) ? pend_ff[3:0] : room;
      sum = {1'b0, bc_ff} + take;
      mask = (BYTE_WHITE >> bc_ff) & ~(BYTE_WHITE >> sum);
   end

   assign emit_next = {1'b0, emit_ff} + 1'b1;
   assign rep_next = {1'b0, rep_ff} + 5'd1;
   assign row_next = {1'b0, row_ff} + 9'd1;
   assign col_next = {1'b0, col_ff} + 9'd1;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      acc_in = acc_ff;
      bc_in = bc_ff;
      len_in = len_ff;
      emit_in = emit_ff;
      rep_in = rep_ff;
      col_in = col_ff;
      row_in = row_ff;
      aside_in = aside_ff;
      adot_in = adot_ff;
      fill_in = fill_ff;
      line_in = line_ff;
      pend_in = pend_ff;
      white_in = white_ff;
      fin_in = fin_ff;
      rdzero_in = rdzero_ff;
      rdbegin_in = rdbegin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in = rsp_byte_ff;
      rsp_bv_in = rsp_bv_ff;
      rsp_last_in = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      wr_en = 1'b0;
      wr_addr = len_ff[ADDR_W-1:0];
      wr_data = acc_ff;
      rd_en = 1'b0;
      rd_addr = emit_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in = BYTE_ZERO;
               rsp_bv_in = 1'b0;
               rsp_last_in = 1'b0;
               rsp_status_in = STATUS_OK;
               case (req_command)
                  CMD_START: begin
                     aside_in = start_side;
                     adot_in = start_dot;
                     fill_in = CNT_W'(start_fill);
                     line_in = CNT_W'(start_fill + {12'd0, start_fill[0]});
                     phase_in = PH_TOP;
                     emit_in = '0;
                     rep_in = '0;
                     row_in = '0;
                     acc_in = '0;
                     bc_in = '0;
                     len_in = '0;
                     col_in = '0;
                     pend_in = {start_dot, 1'b0};
                     white_in = 1'b1;
                     fin_in = FIN_NONE;
                     state_in = S_PIX;
                  end
                  CMD_MODULE: begin
                     if (phase_ff == PH_IDLE) begin
                        rsp_status_in = STATUS_IDLE;
                     end else if (phase_ff == PH_BOTTOM || col_ff >= aside_ff) begin
                        rsp_status_in = STATUS_REFUSED;
                     end else begin
                        col_in = col_next[7:0];
                        pend_in = {1'b0, adot_ff};
                        white_in = !req_dark;
                        fin_in = (col_next == {1'b0, aside_ff}) ? FIN_BORDER : FIN_NONE;
                        state_in = S_PIX;
                     end
                  end
                  CMD_DRAIN: begin
                     if (phase_ff == PH_IDLE) begin
                        rsp_status_in = STATUS_IDLE;
                     end else if (phase_ff == PH_TOP || phase_ff == PH_BOTTOM) begin
                        rsp_byte_in = (emit_ff < fill_ff) ? BYTE_WHITE : BYTE_ZERO;
                        rsp_bv_in = 1'b1;
                        emit_in = emit_next[CNT_W-1:0];
                        if (emit_next >= {1'b0, line_ff}) begin
                           emit_in = '0;
                           rep_in = rep_next[3:0];
                           if (rep_next >= {adot_ff, 1'b0}) begin
                              rep_in = '0;
                              if (phase_ff == PH_TOP) begin
                                 phase_in = PH_DATA;
                              end else begin
                                 phase_in = PH_IDLE;
                                 rsp_last_in = 1'b1;
                              end
                           end
                        end
                     end else if (col_ff < aside_ff) begin
                        rsp_status_in = STATUS_WAIT;
                     end else begin
                        // byte comes from the row store; the RAM registers it and S_READ passes it on
                        rsp_valid_in = 1'b0;
                        rd_en = 1'b1;
                        rdzero_in = !(32'(emit_ff) < MAX_ROW_BYTES);
                        rdbegin_in = 1'b0;
                        state_in = S_READ;
                        emit_in = emit_next[CNT_W-1:0];
                        if (emit_next >= {1'b0, len_ff}) begin
                           emit_in = '0;
                           rep_in = rep_next[3:0];
                           if (rep_next >= {1'b0, adot_ff}) begin
                              rep_in = '0;
                              row_in = row_next[7:0];
                              if (row_next >= {1'b0, aside_ff}) begin
                                 phase_in = PH_BOTTOM;
                              end else begin
                                 acc_in = '0;
                                 bc_in = '0;
                                 len_in = '0;
                                 col_in = '0;
                                 pend_in = {adot_ff, 1'b0};
                                 white_in = 1'b1;
                                 fin_in = FIN_NONE;
                                 rdbegin_in = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PIX: begin
            acc_in = white_ff ? (acc_ff | mask) : acc_ff;
            bc_in = sum[2:0];
            if (sum[3]) begin
               wr_en = 32'(len_ff) < MAX_ROW_BYTES;
               wr_data = white_ff ? (acc_ff | mask) : acc_ff;
               len_in = len_ff + 1'b1;
               acc_in = '0;
               bc_in = '0;
            end
            pend_in = pend_ff - {1'b0, take};
            if (pend_ff == {1'b0, take}) begin
               case (fin_ff)
                  FIN_BORDER: begin
                     pend_in = {adot_ff, 1'b0};
                     white_in = 1'b1;
                     fin_in = FIN_FLUSH;
                  end
                  FIN_FLUSH: begin
                     state_in = S_FLUSH;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FLUSH: begin
            if (bc_ff != 3'd0) begin
               wr_en = 32'(len_ff) < MAX_ROW_BYTES;
               len_in = len_ff + 1'b1;
               acc_in = '0;
               bc_in = '0;
            end
            state_in = S_PAD;
         end
         S_PAD: begin
            // even byte count per row
            if (len_ff[0]) begin
               wr_en = 32'(len_ff) < MAX_ROW_BYTES;
               wr_data = BYTE_ZERO;
               len_in = len_ff + 1'b1;
            end
            state_in = S_IDLE;
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in = rdzero_ff ? BYTE_ZERO : rd_data;
            rsp_bv_in = 1'b1;
            rsp_last_in = 1'b0;
            rsp_status_in = STATUS_OK;
            state_in = rdbegin_ff ? S_PIX : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_RESET;
         dot_ff <= DOT_RESET;
         state_ff <= S_IDLE;
         phase_ff <= PH_IDLE;
         acc_ff <= '0;
         bc_ff <= '0;
         len_ff <= '0;
         emit_ff <= '0;
         rep_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         aside_ff <= '0;
         adot_ff <= '0;
         fill_ff <= '0;
         line_ff <= '0;
         pend_ff <= '0;
         fin_ff <= FIN_NONE;
         rdbegin_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         side_ff <= side_in;
         dot_ff <= dot_in;
         state_ff <= state_in;
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         bc_ff <= bc_in;
         len_ff <= len_in;
         emit_ff <= emit_in;
         rep_ff <= rep_in;
         col_ff <= col_in;
         row_ff <= row_in;
         aside_ff <= aside_in;
         adot_ff <= adot_in;
         fill_ff <= fill_in;
         line_ff <= line_in;
         pend_ff <= pend_in;
         fin_ff <= fin_in;
         rdbegin_ff <= rdbegin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      white_ff <= white_in;
      rdzero_ff <= rdzero_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_bv_ff <= rsp_bv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   mmb_ram #(
      .WIDTH(8),
      .DEPTH(MAX_ROW_BYTES)
   ) u_row_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule
`default_nettype wire
